// File: hdl/slot_free_list_allocator_defines.svh
// assertion macros for the slot allocator
`ifndef SLOT_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define SLOT_FREE_LIST_ALLOCATOR_DEFINES_SVH

// same-cycle implication, off while reset is high
`define SFLA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("slot allocator invariant violated");

// next-cycle implication, off while reset is high
`define SFLA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("slot allocator update violated");

`endif

// File: hdl/slfa_pkg.sv
// types and constants of the slot allocator
`timescale 1ns / 1ps

package slfa_pkg;

   localparam int unsigned SLOT_COUNT = 1024;
   localparam int unsigned SLOT_W     = 10;
   localparam int unsigned COUNT_W    = 11;
   localparam int unsigned TOTAL_W    = 32;

   localparam logic [COUNT_W-1:0] CAP_RESET = 11'd1024;

   typedef enum logic [1:0] {
      REQ_ALLOC      = 2'd0,
      REQ_FREE       = 2'd1,
      REQ_POOL_RESET = 2'd2,
      REQ_NOP        = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_EXHAUSTED   = 2'd1,
      STATUS_DOUBLE_FREE = 2'd2,
      STATUS_RANGE       = 2'd3
   } status_type;

endpackage

// File: hdl/slot_free_list_allocator.sv
// slot allocator top level: lifo free list, in-use bitmap and statistics
`timescale 1ns / 1ps
`include "slot_free_list_allocator_defines.svh"

// channel    direction  handshake              payload
// req_       in         req_valid/req_ready    req_type, req_slot_index
// rsp_       out        rsp_valid/rsp_ready    status, granted slot, counts, totals
// csr_       in         csr_valid/csr_ready    csr_capacity_in_use
//
// a request is taken in every cycle unless a stalled result holds the request stage; its result is registered
// in two steps (request register with the memory reads, then execute into the result register)
// the next-link read is prefetched one entry ahead so allocations run back to back
// rsp stall holds the request stage; a new request still lands in an empty request stage while a result waits
// synchronous reset clears control, list, fill count, counters and capacity (1024)
// bitmap and link memories need no clearing pass: a bit counts only below fresh_next

module slot_free_list_allocator
   import slfa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [9:0]  req_slot_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [9:0]  rsp_granted_slot,
   output logic [10:0] rsp_in_use_count,
   output logic [10:0] rsp_peak_count,
   output logic [31:0] rsp_alloc_total,
   output logic [31:0] rsp_free_total,
   output logic [31:0] rsp_exhausted_total,
   output logic [31:0] rsp_double_free_total,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [10:0] csr_capacity_in_use
);

   // memories: in-use bitmap and next links of the freed list
   logic               bitmap_mem [SLOT_COUNT];
   logic [COUNT_W-1:0] link_mem   [SLOT_COUNT];

   // request stage
   logic               s1_valid_ff, s1_valid_in;
   req_kind_type       s1_kind_ff;
   logic [SLOT_W-1:0]  s1_index_ff;
   logic               bit_rdata_ff;
   logic [COUNT_W-1:0] link_rdata_ff;

   // pool state
   logic [COUNT_W-1:0] cap_ff;
   logic [COUNT_W-1:0] head_ff, head_in;
   logic [COUNT_W-1:0] second_ff, second_in;
   logic               pending_ff, pending_in;
   logic [COUNT_W-1:0] fresh_ff, fresh_in;
   logic [COUNT_W-1:0] in_use_ff, in_use_in;
   logic [COUNT_W-1:0] peak_ff, peak_in;
   logic [TOTAL_W-1:0] alloc_tot_ff, alloc_tot_in;
   logic [TOTAL_W-1:0] free_tot_ff, free_tot_in;
   logic [TOTAL_W-1:0] exh_tot_ff, exh_tot_in;
   logic [TOTAL_W-1:0] dbl_tot_ff, dbl_tot_in;

   // last bitmap write, covers the read taken at the same edge
   logic               byp_valid_ff, byp_valid_in;
   logic [SLOT_W-1:0]  byp_addr_ff, byp_addr_in;
   logic               byp_value_ff, byp_value_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff;
   logic [SLOT_W-1:0]  rsp_granted_ff;

   // execute controls
   logic               accept;
   logic               exec_fire;
   logic               bit_we, bit_wdata;
   logic [SLOT_W-1:0]  bit_waddr;
   logic               link_we, link_re;
   logic [SLOT_W-1:0]  link_waddr, link_raddr;
   logic [COUNT_W-1:0] link_wdata;
   logic [COUNT_W-1:0] second_eff;
   logic [COUNT_W-1:0] eff_cap;
   logic               slot_busy;
   logic               alloc_ok;
   status_type         status_c;
   logic [SLOT_W-1:0]  granted_c;

   // handshakes
   assign exec_fire = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || exec_fire;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // capacity above the pool size acts as the pool size
   assign eff_cap = (cap_ff > COUNT_W'(SLOT_COUNT)) ? COUNT_W'(SLOT_COUNT) : cap_ff;

   // link below the head: prefetched read data after a pop, else the register
   assign second_eff = pending_ff ? link_rdata_ff : second_ff;

   // a bitmap entry is meaningful only below the fresh index
   always_comb begin
      logic raw_bit;
      raw_bit = (byp_valid_ff && byp_addr_ff == s1_index_ff) ? byp_value_ff : bit_rdata_ff;
      slot_busy = ({1'b0, s1_index_ff} < fresh_ff) && raw_bit;
   end

   // execute one request
   always_comb begin
      head_in      = head_ff;
      second_in    = second_ff;
      pending_in   = pending_ff;
      fresh_in     = fresh_ff;
      in_use_in    = in_use_ff;
      peak_in      = peak_ff;
      alloc_tot_in = alloc_tot_ff;
      free_tot_in  = free_tot_ff;
      exh_tot_in   = exh_tot_ff;
      dbl_tot_in   = dbl_tot_ff;
      byp_valid_in = byp_valid_ff;
      byp_addr_in  = byp_addr_ff;
      byp_value_in = byp_value_ff;
      bit_we       = 1'b0;
      bit_waddr    = s1_index_ff;
      bit_wdata    = 1'b0;
      link_we      = 1'b0;
      link_waddr   = s1_index_ff;
      link_wdata   = head_ff;
      link_re      = 1'b0;
      link_raddr   = SLOT_W'(second_eff - COUNT_W'(1));
      alloc_ok     = 1'b0;
      status_c     = STATUS_OK;
      granted_c    = '0;

      if (exec_fire) begin
         byp_valid_in = 1'b0;
         case (s1_kind_ff)
            REQ_ALLOC: begin
               if (head_ff != '0) begin
                  // pop the freed list, prefetch the link below the new head
                  alloc_ok   = 1'b1;
                  granted_c  = SLOT_W'(head_ff - COUNT_W'(1));
                  head_in    = second_eff;
                  link_re    = 1'b1;
                  pending_in = 1'b1;
               end else if (fresh_ff < eff_cap) begin
                  alloc_ok  = 1'b1;
                  granted_c = SLOT_W'(fresh_ff);
                  fresh_in  = fresh_ff + COUNT_W'(1);
               end else begin
                  status_c   = STATUS_EXHAUSTED;
                  exh_tot_in = exh_tot_ff + TOTAL_W'(1);
               end
               if (alloc_ok) begin
                  bit_we       = 1'b1;
                  bit_waddr    = granted_c;
                  bit_wdata    = 1'b1;
                  byp_valid_in = 1'b1;
                  byp_addr_in  = granted_c;
                  byp_value_in = 1'b1;
                  in_use_in    = in_use_ff + COUNT_W'(1);
                  if (in_use_in > peak_ff) begin
                     peak_in = in_use_in;
                  end
                  alloc_tot_in = alloc_tot_ff + TOTAL_W'(1);
               end
            end
            REQ_FREE: begin
               if ({1'b0, s1_index_ff} >= eff_cap) begin
                  status_c = STATUS_RANGE;
               end else if (!slot_busy) begin
                  status_c   = STATUS_DOUBLE_FREE;
                  dbl_tot_in = dbl_tot_ff + TOTAL_W'(1);
               end else begin
                  // push: old head becomes the link below, no read needed
                  bit_we       = 1'b1;
                  bit_wdata    = 1'b0;
                  byp_valid_in = 1'b1;
                  byp_addr_in  = s1_index_ff;
                  byp_value_in = 1'b0;
                  link_we      = 1'b1;
                  head_in      = {1'b0, s1_index_ff} + COUNT_W'(1);
                  second_in    = head_ff;
                  pending_in   = 1'b0;
                  if (in_use_ff != '0) begin
                     in_use_in = in_use_ff - COUNT_W'(1);
                  end
                  free_tot_in = free_tot_ff + TOTAL_W'(1);
               end
            end
            REQ_POOL_RESET: begin
               // totals and peak survive
               head_in    = '0;
               second_in  = '0;
               pending_in = 1'b0;
               fresh_in   = '0;
               in_use_in  = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      s1_valid_in  = accept ? 1'b1 : (exec_fire ? 1'b0 : s1_valid_ff);
      rsp_valid_in = exec_fire ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   // bitmap: read at acceptance, written at execute
   always_ff @(posedge clock) begin
      if (bit_we) begin
         bitmap_mem[bit_waddr] <= bit_wdata;
      end
      if (accept) begin
         bit_rdata_ff <= bitmap_mem[req_slot_index];
      end
   end

   // link memory: written on a free, read on a pop
   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      if (link_re) begin
         link_rdata_ff <= link_mem[link_raddr];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kind_ff  <= req_kind_type'(req_type);
         s1_index_ff <= req_slot_index;
      end
      if (exec_fire) begin
         rsp_status_ff  <= status_c;
         rsp_granted_ff <= granted_c;
      end
      byp_addr_ff  <= byp_addr_in;
      byp_value_ff <= byp_value_in;
      second_ff    <= second_in;
   end

   // control and pool state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cap_ff       <= CAP_RESET;
         head_ff      <= '0;
         pending_ff   <= 1'b0;
         fresh_ff     <= '0;
         in_use_ff    <= '0;
         peak_ff      <= '0;
         alloc_tot_ff <= '0;
         free_tot_ff  <= '0;
         exh_tot_ff   <= '0;
         dbl_tot_ff   <= '0;
         byp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            cap_ff <= csr_capacity_in_use;
         end
         head_ff      <= head_in;
         pending_ff   <= pending_in;
         fresh_ff     <= fresh_in;
         in_use_ff    <= in_use_in;
         peak_ff      <= peak_in;
         alloc_tot_ff <= alloc_tot_in;
         free_tot_ff  <= free_tot_in;
         exh_tot_ff   <= exh_tot_in;
         dbl_tot_ff   <= dbl_tot_in;
         byp_valid_ff <= byp_valid_in;
      end
   end

   // statistics in the result follow the state after the request
   logic [COUNT_W-1:0] rsp_in_use_ff, rsp_peak_ff;
   logic [TOTAL_W-1:0] rsp_alloc_ff, rsp_free_ff, rsp_exh_ff, rsp_dbl_ff;

   always_ff @(posedge clock) begin
      if (exec_fire) begin
         rsp_in_use_ff <= in_use_in;
         rsp_peak_ff   <= peak_in;
         rsp_alloc_ff  <= alloc_tot_in;
         rsp_free_ff   <= free_tot_in;
         rsp_exh_ff    <= exh_tot_in;
         rsp_dbl_ff    <= dbl_tot_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_granted_slot      = rsp_granted_ff;
   assign rsp_in_use_count      = rsp_in_use_ff;
   assign rsp_peak_count        = rsp_peak_ff;
   assign rsp_alloc_total       = rsp_alloc_ff;
   assign rsp_free_total        = rsp_free_ff;
   assign rsp_exhausted_total   = rsp_exh_ff;
   assign rsp_double_free_total = rsp_dbl_ff;

   // listed slots were all handed out since the pool reset, so they lie below fresh_next
   `SFLA_ASSERT_NOW(a_head_below_fresh, clock, reset, head_ff != '0, head_ff <= fresh_ff)
   // every slot in use lies below fresh_next
   `SFLA_ASSERT_NOW(a_in_use_below_fresh, clock, reset, 1'b1, in_use_ff <= fresh_ff)
   // a refused request grants no slot
   `SFLA_ASSERT_NOW(a_no_grant_on_error, clock, reset, exec_fire && status_c != STATUS_OK, granted_c == '0)
   // a granted allocation raises the in-use count by one
   `SFLA_ASSERT_NEXT(a_alloc_counts, clock, reset, exec_fire && alloc_ok, in_use_ff == $past(in_use_ff) + COUNT_W'(1))

endmodule

// File: tb/sv/testbench.sv
// self-checking testbench for the slot allocator: request driver, result monitor, predictor
`timescale 1ns / 1ps

module testbench;
   import slfa_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned LONG_HOLD   = 300;

   // one request as the driver presents it
   typedef struct packed {
      req_kind_type kind;
      logic [9:0]   slot;
      logic         wait_drain;   // hold this request back until every result is in
   } slot_request_type;

   // one result as the block should report it
   typedef struct packed {
      status_type   status;
      logic [9:0]   granted;
      logic [10:0]  in_use;
      logic [10:0]  peak;
      logic [31:0]  allocs;
      logic [31:0]  frees;
      logic [31:0]  exhausts;
      logic [31:0]  double_frees;
   } slot_outcome_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_type = REQ_NOP;
   logic [9:0]  req_slot_index = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [9:0]  rsp_granted_slot;
   logic [10:0] rsp_in_use_count;
   logic [10:0] rsp_peak_count;
   logic [31:0] rsp_alloc_total;
   logic [31:0] rsp_free_total;
   logic [31:0] rsp_exhausted_total;
   logic [31:0] rsp_double_free_total;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [10:0] csr_capacity_in_use = CAP_RESET;

   slot_free_list_allocator dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_type              (req_type),
      .req_slot_index        (req_slot_index),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_status            (rsp_status),
      .rsp_granted_slot      (rsp_granted_slot),
      .rsp_in_use_count      (rsp_in_use_count),
      .rsp_peak_count        (rsp_peak_count),
      .rsp_alloc_total       (rsp_alloc_total),
      .rsp_free_total        (rsp_free_total),
      .rsp_exhausted_total   (rsp_exhausted_total),
      .rsp_double_free_total (rsp_double_free_total),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_capacity_in_use   (csr_capacity_in_use)
   );

   // 4 ns period
   always #2 clock = ~clock;

   // stimulus and scoreboard storage
   slot_request_type request_queue[$];
   slot_outcome_type pending_outcomes[$];

   // handshakes seen at the last rising edge, read by the falling-edge drivers
   logic req_seen = 1'b0;
   logic csr_seen = 1'b0;

   // run control written by the sequencing block only
   bit long_hold_go = 1'b0;
   bit quiet_tail   = 1'b0;

   int unsigned cycle_count    = 0;
   int unsigned mismatch_count = 0;
   int unsigned request_count  = 0;
   int unsigned result_count   = 0;
   int unsigned setting_count  = 0;

   // predictor state: its own copy of the pool, the list and the statistics
   logic [10:0] cap_setting = CAP_RESET;
   logic [10:0] list_top    = '0;          // freed list head as slot+1, zero when empty
   logic [10:0] fresh_slot  = '0;          // next never-handed-out slot
   logic [10:0] chain [SLOT_COUNT];        // link below each listed slot
   bit          busy_map [SLOT_COUNT];
   logic [10:0] in_use_now  = '0;
   logic [10:0] peak_seen   = '0;
   logic [31:0] allocs      = '0;
   logic [31:0] frees       = '0;
   logic [31:0] exhausts    = '0;
   logic [31:0] double_frees = '0;

   initial begin
      foreach (busy_map[i]) begin
         busy_map[i] = 1'b0;
         chain[i]    = '0;
      end
   end

   // advance the predicted pool by one request and report what the block should answer
   function automatic slot_outcome_type allocator_outcome(req_kind_type kind, logic [9:0] index);
      slot_outcome_type result;
      logic [10:0]   limit;
      logic [9:0]    slot;
      bit            got;
      // capacity above the pool size acts as the pool size
      limit = (cap_setting > CAP_RESET) ? CAP_RESET : cap_setting;
      result.status  = STATUS_OK;
      result.granted = '0;
      slot = '0;
      got  = 1'b0;
      case (kind)
         REQ_ALLOC: begin
            // freed list first, then fresh slots below the capacity
            if (list_top != '0) begin
               slot     = 10'(list_top - 11'd1);
               list_top = chain[slot];
               got      = 1'b1;
            end else if (fresh_slot < limit) begin
               slot       = fresh_slot[9:0];
               fresh_slot = fresh_slot + 11'd1;
               got        = 1'b1;
            end
            if (got) begin
               busy_map[slot] = 1'b1;
               in_use_now     = in_use_now + 11'd1;
               if (in_use_now > peak_seen)
                  peak_seen = in_use_now;
               allocs         = allocs + 32'd1;
               result.granted = slot;
            end else begin
               exhausts      = exhausts + 32'd1;
               result.status = STATUS_EXHAUSTED;
            end
         end
         REQ_FREE: begin
            if ({1'b0, index} >= limit) begin
               result.status = STATUS_RANGE;
            end else if (!busy_map[index]) begin
               double_frees  = double_frees + 32'd1;
               result.status = STATUS_DOUBLE_FREE;
            end else begin
               busy_map[index] = 1'b0;
               chain[index]    = list_top;
               list_top        = {1'b0, index} + 11'd1;
               if (in_use_now != '0)
                  in_use_now = in_use_now - 11'd1;
               frees = frees + 32'd1;
            end
         end
         REQ_POOL_RESET: begin
            // peak and totals survive a pool reset
            foreach (busy_map[i])
               busy_map[i] = 1'b0;
            list_top   = '0;
            fresh_slot = '0;
            in_use_now = '0;
         end
         default: begin
            // no operation, statistics only
         end
      endcase
      result.in_use       = in_use_now;
      result.peak         = peak_seen;
      result.allocs       = allocs;
      result.frees        = frees;
      result.exhausts     = exhausts;
      result.double_frees = double_frees;
      return result;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   // rising-edge monitor: takes requests into the predictor, checks results
   always @(posedge clock) begin : result_monitor
      slot_outcome_type want;
      req_seen <= req_valid && req_ready;
      csr_seen <= csr_valid && csr_ready;
      if (!reset) begin
         cycle_count++;
         if (csr_valid && csr_ready) begin
            cap_setting = csr_capacity_in_use;
         end
         if (req_valid && req_ready) begin
            request_count++;
            pending_outcomes.push_back(
               allocator_outcome(req_kind_type'(req_type), req_slot_index));
         end
         if (rsp_valid && rsp_ready) begin
            result_count++;
            if (pending_outcomes.size() == 0) begin
               $error("result with no request waiting for it");
               mismatch_count++;
            end else begin
               want = pending_outcomes.pop_front();
               check_field("status", want.status, rsp_status);
               check_field("granted_slot", want.granted, rsp_granted_slot);
               check_field("in_use_count", want.in_use, rsp_in_use_count);
               check_field("peak_count", want.peak, rsp_peak_count);
               check_field("alloc_total", want.allocs, rsp_alloc_total);
               check_field("free_total", want.frees, rsp_free_total);
               check_field("exhausted_total", want.exhausts, rsp_exhausted_total);
               check_field("double_free_total", want.double_frees, rsp_double_free_total);
            end
         end
      end
   end

   // falling-edge request driver, fed from the request queue
   always @(negedge clock) begin : request_driver
      slot_request_type item;
      bit            offer;
      int unsigned   send_gap;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else if (!(req_valid && !req_seen)) begin
         // previous request taken or none offered: pick what to do next
         offer = 1'b0;
         if (send_gap != 0) begin
            send_gap--;
         end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            // idle burst of random length
            send_gap = $urandom_range(0, 10);
         end else if (request_queue.size() != 0 &&
                      !(request_queue[0].wait_drain && pending_outcomes.size() != 0)) begin
            item = request_queue.pop_front();
            req_type       <= item.kind;
            req_slot_index <= item.slot;
            offer = 1'b1;
         end
         req_valid <= offer;
      end
   end

   // falling-edge result ready: random stall bursts plus one long hold-off
   always @(negedge clock) begin : result_receiver
      bit          take;
      bit          long_hold_taken;
      int unsigned hold_left;
      int unsigned stall_left;
      if (reset) begin
         rsp_ready <= 1'b0;
         long_hold_taken = 1'b0;
         hold_left  = 0;
         stall_left = 0;
      end else begin
         take = 1'b0;
         if (long_hold_go && !long_hold_taken) begin
            long_hold_taken = 1'b1;
            hold_left = LONG_HOLD;
         end
         if (hold_left != 0) begin
            hold_left--;
         end else if (stall_left != 0) begin
            stall_left--;
         end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 10);
         end else begin
            take = 1'b1;
         end
         rsp_ready <= take;
      end
   end

   // run ends here if the block hangs
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT)
         @(posedge clock);
      $display("Mismatches found");
      $finish;
   end

   task automatic push_request(req_kind_type kind, logic [9:0] slot, bit drain = 1'b0);
      slot_request_type item;
      item.kind       = kind;
      item.slot       = slot;
      item.wait_drain = drain;
      request_queue.push_back(item);
   endtask

   // wait until every queued request is answered, then let the pipeline settle
   task automatic wait_idle();
      do
         @(posedge clock);
      while (request_queue.size() != 0 || req_valid || pending_outcomes.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // capacity write, only while the block is idle
   task automatic write_capacity(logic [10:0] value);
      wait_idle();
      @(negedge clock);
      csr_valid           <= 1'b1;
      csr_capacity_in_use <= value;
      do
         @(negedge clock);
      while (!csr_seen);
      csr_valid <= 1'b0;
      setting_count++;
      @(posedge clock);
   endtask

   // some slot the predictor holds as in use, or any slot if none is
   function automatic logic [9:0] busy_slot_pick();
      int unsigned start;
      start = $urandom_range(0, SLOT_COUNT - 1);
      for (int unsigned k = 0; k < SLOT_COUNT; k++) begin
         if (busy_map[(start + k) % SLOT_COUNT])
            return 10'((start + k) % SLOT_COUNT);
      end
      return 10'($urandom_range(0, SLOT_COUNT - 1));
   endfunction

   // mostly alloc/free pairs on live slots, some noise around the capacity edge
   task automatic random_request(logic [10:0] capacity, bit drain);
      int unsigned pick;
      int unsigned edge_slot;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         push_request(REQ_ALLOC, 10'($urandom_range(0, 1023)), drain);
      end else if (pick < 80) begin
         push_request(REQ_FREE, busy_slot_pick(), drain);
      end else if (pick < 88) begin
         push_request(REQ_FREE, 10'($urandom_range(0, 1023)), drain);
      end else if (pick < 93) begin
         // just below, at and above the capacity
         edge_slot = capacity + $urandom_range(0, 2);
         edge_slot = (edge_slot == 0) ? 0 : edge_slot - 1;
         if (edge_slot > 1023)
            edge_slot = 1023;
         push_request(REQ_FREE, 10'(edge_slot), drain);
      end else if (pick < 97) begin
         push_request(REQ_NOP, 10'($urandom_range(0, 1023)), drain);
      end else begin
         push_request(REQ_POOL_RESET, 10'($urandom_range(0, 1023)), drain);
      end
   endtask

   task automatic run_random_phase(logic [10:0] capacity, int unsigned count,
                                   int unsigned drain_every);
      bit drain;
      write_capacity(capacity);
      for (int unsigned i = 0; i < count; i++) begin
         // keep the queue short so picks follow the live pool
         while (request_queue.size() >= 3)
            @(posedge clock);
         drain = (drain_every != 0) && (i % drain_every == drain_every - 1);
         random_request(capacity, drain);
      end
   endtask

   initial begin : sequencer
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // basic allocate and free at reset capacity, lifo reuse, no operation, pool reset
      push_request(REQ_ALLOC, 10'd1023);
      push_request(REQ_ALLOC, 10'd0);
      push_request(REQ_FREE, 10'd1);
      push_request(REQ_FREE, 10'd1);          // double free
      push_request(REQ_FREE, 10'd1023);       // never allocated
      push_request(REQ_FREE, 10'd0);
      push_request(REQ_ALLOC, 10'd0);         // last freed comes back first
      push_request(REQ_ALLOC, 10'd0);
      push_request(REQ_ALLOC, 10'd0);         // fresh slot again
      push_request(REQ_NOP, 10'd1023);
      push_request(REQ_POOL_RESET, 10'd0);
      push_request(REQ_FREE, 10'd0);          // slot 0 counts as free after the pool reset
      push_request(REQ_ALLOC, 10'd0);

      // empty pool: every allocation refused, every free out of range
      write_capacity(11'd0);
      push_request(REQ_ALLOC, 10'd0);
      push_request(REQ_FREE, 10'd1023);

      // capacity above the pool size acts as the pool size
      write_capacity(11'h7FF);
      push_request(REQ_FREE, 10'd1023);
      push_request(REQ_FREE, 10'd0);

      // single slot pool
      write_capacity(11'd1);
      push_request(REQ_POOL_RESET, 10'd0);
      push_request(REQ_ALLOC, 10'd0);
      push_request(REQ_ALLOC, 10'd0);
      push_request(REQ_FREE, 10'd1);

      // shrink while freed slots above the new capacity sit on the list
      write_capacity(11'd1024);
      push_request(REQ_ALLOC, 10'd0);
      push_request(REQ_ALLOC, 10'd0);
      push_request(REQ_FREE, 10'd2);
      push_request(REQ_FREE, 10'd1);
      write_capacity(11'd1);
      push_request(REQ_ALLOC, 10'd0);
      push_request(REQ_FREE, 10'd2);

      // fill a 64-slot pool, run it dry, release and reuse the top slot
      write_capacity(11'd64);
      push_request(REQ_POOL_RESET, 10'd0);
      for (int unsigned i = 0; i < 66; i++)
         push_request(REQ_ALLOC, 10'($urandom_range(0, 1023)));
      push_request(REQ_FREE, 10'd63);
      push_request(REQ_FREE, 10'd63);
      push_request(REQ_ALLOC, 10'd0);
      push_request(REQ_POOL_RESET, 10'd0);

      // random phases over a spread of capacities
      run_random_phase(11'd1024, 100, 0);
      wait_idle();
      long_hold_go = 1'b1;                    // receiver holds off while requests pile up
      run_random_phase(11'd16, 110, 0);
      run_random_phase(11'd1, 60, 0);
      run_random_phase(11'h7FF, 110, 25);     // sender drains every 25th request
      run_random_phase(11'd0, 30, 0);
      run_random_phase(11'd5, 110, 0);
      run_random_phase(11'd300, 120, 0);
      run_random_phase(11'd2, 60, 0);
      wait_idle();
      quiet_tail = 1'b1;                      // back-to-back to the end
      run_random_phase(11'd1024, 110, 0);

      wait_idle();
      repeat (10) @(posedge clock);
      $display("covered %0d requests and %0d results over %0d capacity settings",
               request_count, result_count, setting_count);
      $display("peak %0d slots, %0d refused allocations, %0d rejected frees",
               peak_seen, exhausts, double_frees);
      if (mismatch_count == 0 && pending_outcomes.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
